[hw/rtl/gcd_lcm_bezout_unit_top_macros.svh]
// Assertion macros for the gcd/lcm/Bezout unit
`ifndef GCD_LCM_BEZOUT_UNIT_TOP_MACROS_SVH
`define GCD_LCM_BEZOUT_UNIT_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define GLB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define GLB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[hw/rtl/glb_pkg.sv]
//------------------------------------------------------------------------------
// glb_pkg: shared types for the gcd/lcm/Bezout unit
// Controller states and the command/status structs between control and datapath.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package glb_pkg;
   localparam int DATA_WIDTH_DEF = 64;
   localparam int FIELD_WIDTH    = 63;
   localparam int COEF_WIDTH     = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,      // divide r0 by r1
      ST_MULS,     // s update multiply
      ST_MULT,     // t update multiply
      ST_LDIV,     // a / g
      ST_LMUL,     // (a/g) * b
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;       // capture operands
      logic div_start;  // start divider on r0 / r1
      logic ldiv_start; // start divider on a / g
      logic mul_s;      // q * s1 multiply request
      logic mul_t;      // q * t1 multiply request
      logic mul_l;      // (a/g) * b multiply request
      logic rotate;     // shift remainder and coefficient sequences
      logic finish;     // lcm result capture
   } cmd_type;

   typedef struct packed {
      logic r1_zero;
      logic div_done;
      logic mul_done;
      logic ab_nonzero;
   } sts_type;
endpackage

[hw/rtl/glb_datapath.sv]
//------------------------------------------------------------------------------
// glb_datapath: registers and shared iterative units
// Euclid remainder sequence, restoring divider, shift-add multiplier.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_lcm_bezout_unit_top_macros.svh"
module glb_datapath #(
   parameter int DATA_WIDTH = glb_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  glb_pkg::cmd_type                cmd,
   output glb_pkg::sts_type                sts,
   input  logic [glb_pkg::FIELD_WIDTH-1:0] req_operand_a,
   input  logic [glb_pkg::FIELD_WIDTH-1:0] req_operand_b,
   output logic [glb_pkg::FIELD_WIDTH-1:0] gcd_o,
   output logic [glb_pkg::COEF_WIDTH-1:0]  x_o,
   output logic [glb_pkg::COEF_WIDTH-1:0]  y_o,
   output logic [glb_pkg::FIELD_WIDTH-1:0] lcm_o,
   output logic                            ovf_o
);
   localparam int OW = DATA_WIDTH - 1;        // operand width
   localparam int CW = glb_pkg::COEF_WIDTH;
   localparam int DCW = $clog2(OW + 1);
   localparam int MCW = $clog2(CW + 1);
   localparam logic [OW-1:0] OMAX = {OW{1'b1}};

   logic [OW-1:0] a_ff, a_in, b_ff, b_in;
   logic [OW-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [CW-1:0] s0_ff, s0_in, s1_ff, s1_in, t0_ff, t0_in, t1_ff, t1_in;
   // divider
   logic [OW-1:0]  dq_ff, dq_in, drem_ff, drem_in, dd_ff, dd_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic           dbusy_ff, dbusy_in;
   logic [OW:0]    dtrial;
   logic [OW:0]    dsub;
   // multiplier: acc += mcand when mplier bit set
   logic [CW-1:0]  macc_ff, macc_in, mcand_ff, mcand_in, mpl_ff, mpl_in;
   logic [MCW-1:0] mcnt_ff, mcnt_in;
   logic           mbusy_ff, mbusy_in, mhi_ff, mhi_in;
   logic [CW-1:0]  mcand_sh;
   logic [OW-1:0]  lcm_ff, lcm_in;
   logic           ovf_ff, ovf_in;
   logic           mul_any;
   // q*s1 product, held while the t multiply reuses the accumulator
   logic [CW-1:0]  qs_ff, qs_in;

   assign mul_any = cmd.mul_s | cmd.mul_t | cmd.mul_l;
   assign dtrial  = {drem_ff, dd_ff[OW-1]};
   assign dsub    = dtrial - {1'b0, r1_ff};
   assign mcand_sh = {mcand_ff[CW-2:0], 1'b0};

   // next-state logic
   always_comb begin
      a_in = a_ff; b_in = b_ff; r0_in = r0_ff; r1_in = r1_ff;
      s0_in = s0_ff; s1_in = s1_ff; t0_in = t0_ff; t1_in = t1_ff;
      dq_in = dq_ff; drem_in = drem_ff; dd_in = dd_ff; dcnt_in = dcnt_ff;
      dbusy_in = dbusy_ff;
      macc_in = macc_ff; mcand_in = mcand_ff; mpl_in = mpl_ff; mcnt_in = mcnt_ff;
      mbusy_in = mbusy_ff; mhi_in = mhi_ff;
      lcm_in = lcm_ff; ovf_in = ovf_ff;
      if (cmd.load) begin
         a_in = req_operand_a[OW-1:0]; b_in = req_operand_b[OW-1:0];
         r0_in = req_operand_a[OW-1:0]; r1_in = req_operand_b[OW-1:0];
         s0_in = CW'(1); s1_in = '0; t0_in = '0; t1_in = CW'(1);
      end
      // divider start: r0/r1 or a/g (g sits in r0 then, divisor swapped in)
      if (cmd.div_start) begin
         dd_in = r0_ff; drem_in = '0; dq_in = '0;
         dcnt_in = DCW'(OW); dbusy_in = 1'b1;
      end else if (cmd.ldiv_start) begin
         dd_in = a_ff; drem_in = '0; dq_in = '0;
         r1_in = r0_ff;                 // divisor = g
         dcnt_in = DCW'(OW); dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         dd_in = {dd_ff[OW-2:0], 1'b0};
         if (!dsub[OW]) begin
            drem_in = dsub[OW-1:0]; dq_in = {dq_ff[OW-2:0], 1'b1};
         end else begin
            drem_in = dtrial[OW-1:0]; dq_in = {dq_ff[OW-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - DCW'(1);
         if (dcnt_ff == DCW'(1)) dbusy_in = 1'b0;
      end
      // multiplier: one bit per cycle, low CW bits of product
      if (mul_any && !mbusy_ff && !mhi_ff) begin
         macc_in = '0; mpl_in = CW'(dq_ff); mbusy_in = 1'b1; mhi_in = 1'b0;
         mcnt_in = MCW'(CW);
         if (cmd.mul_s) mcand_in = s1_ff;
         else if (cmd.mul_t) mcand_in = t1_ff;
         else mcand_in = CW'(b_ff);
      end else if (mbusy_ff) begin
         if (mpl_ff[0]) begin
            macc_in = macc_ff + mcand_ff;
            if (cmd.mul_l && ({1'b0, macc_ff} + {1'b0, mcand_ff} > {1'b0, CW'(OMAX)}))
               mhi_in = 1'b1;
         end
         if (cmd.mul_l && mcand_ff[CW-1] && (mpl_ff >> 1) != '0) mhi_in = 1'b1;
         mcand_in = mcand_sh; mpl_in = mpl_ff >> 1;
         mcnt_in = mcnt_ff - MCW'(1);
         if (mcnt_ff == MCW'(1)) mbusy_in = 1'b0;
      end else if (mhi_ff && !mul_any) begin
         mhi_in = 1'b0;
      end
      // rotate: apply remainder and coefficient updates after the t multiply
      if (cmd.rotate) begin
         r0_in = r1_ff; r1_in = drem_ff;
         s0_in = s1_ff; s1_in = s0_ff - qs_ff;
         t0_in = t1_ff; t1_in = t0_ff - macc_ff;   // macc holds q*t1
      end
      if (cmd.finish) begin
         if (mhi_ff || (macc_ff > CW'(OMAX))) begin
            lcm_in = OMAX; ovf_in = 1'b1;
         end else begin
            lcm_in = macc_ff[OW-1:0]; ovf_in = 1'b0;
         end
         mhi_in = 1'b0;
      end
      if (cmd.load) begin
         lcm_in = '0; ovf_in = 1'b0; mhi_in = 1'b0;
      end
   end

   // q*s1 result in macc is cleared once the t multiply starts, so stash it
   always_comb begin
      qs_in = qs_ff;
      if (cmd.mul_t && !mbusy_ff && !mhi_ff) qs_in = macc_ff;
   end

   // registers
   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; r0_ff <= r0_in; r1_ff <= r1_in;
      s0_ff <= s0_in; t0_ff <= t0_in;
      s1_ff <= s1_in; t1_ff <= t1_in;
      dq_ff <= dq_in; drem_ff <= drem_in; dd_ff <= dd_in; dcnt_ff <= dcnt_in;
      macc_ff <= macc_in; mcand_ff <= mcand_in; mpl_ff <= mpl_in; mcnt_ff <= mcnt_in;
      qs_ff <= qs_in; lcm_ff <= lcm_in; ovf_ff <= ovf_in;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0; mbusy_ff <= 1'b0; mhi_ff <= 1'b0;
      end else begin
         dbusy_ff <= dbusy_in; mbusy_ff <= mbusy_in; mhi_ff <= mhi_in;
      end
   end

   // status and results
   assign sts.r1_zero    = (r1_ff == '0);
   assign sts.div_done   = !dbusy_ff;
   assign sts.mul_done   = !mbusy_ff;
   assign sts.ab_nonzero = (a_ff != '0) && (b_ff != '0);
   assign gcd_o = glb_pkg::FIELD_WIDTH'(r0_ff);
   assign x_o   = s0_ff;
   assign y_o   = t0_ff;
   assign lcm_o = glb_pkg::FIELD_WIDTH'(lcm_ff);
   assign ovf_o = ovf_ff;

   `GLB_ASSERT_IMP(a_div_mul_excl, clock, reset, dbusy_ff, !mbusy_ff, "divider and multiplier overlap")
   `GLB_ASSERT_NXT(a_div_starts, clock, reset, cmd.div_start, dbusy_ff, "divider did not start")
   `GLB_ASSERT_IMP(a_rot_idle, clock, reset, cmd.rotate, !dbusy_ff && !mbusy_ff, "rotate while busy")
endmodule

[hw/rtl/glb_ctrl.sv]
//------------------------------------------------------------------------------
// glb_ctrl: sequencing state machine
// Steps Euclid iterations, then, if both operands are nonzero, the lcm divide and multiply.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_lcm_bezout_unit_top_macros.svh"
module glb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             done_o,
   output glb_pkg::cmd_type cmd,
   input  glb_pkg::sts_type sts
);
   glb_pkg::state_type state_ff, state_in;
   logic               go_ff, go_in;   // first cycle of ST_DIV or of a multiply state

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glb_pkg::ST_IDLE; go_ff <= 1'b0;
      end else begin
         state_ff <= state_in; go_ff <= go_in;
      end
   end

   // next state and commands; a multiply command drops in its done cycle
   always_comb begin
      state_in = state_ff; go_in = 1'b0; cmd = '0; done_o = 1'b0;
      busy = (state_ff != glb_pkg::ST_IDLE);
      unique case (state_ff)
         glb_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1; state_in = glb_pkg::ST_DIV; go_in = 1'b1;
            end
         end
         glb_pkg::ST_DIV: begin
            if (go_ff) begin
               if (sts.r1_zero) begin
                  if (sts.ab_nonzero) begin
                     cmd.ldiv_start = 1'b1; state_in = glb_pkg::ST_LDIV;
                  end else state_in = glb_pkg::ST_DONE;
               end else cmd.div_start = 1'b1;
            end else if (sts.div_done) begin
               state_in = glb_pkg::ST_MULS; go_in = 1'b1;
            end
         end
         glb_pkg::ST_MULS: begin
            cmd.mul_s = 1'b1;
            if (!go_ff && sts.mul_done) begin
               cmd.mul_s = 1'b0;
               state_in = glb_pkg::ST_MULT; go_in = 1'b1;
            end
         end
         glb_pkg::ST_MULT: begin
            cmd.mul_t = 1'b1;
            if (!go_ff && sts.mul_done) begin
               cmd.mul_t = 1'b0; cmd.rotate = 1'b1;
               state_in = glb_pkg::ST_DIV; go_in = 1'b1;
            end
         end
         glb_pkg::ST_LDIV: begin
            if (sts.div_done) begin
               state_in = glb_pkg::ST_LMUL; go_in = 1'b1;
            end
         end
         glb_pkg::ST_LMUL: begin
            cmd.mul_l = 1'b1;
            if (!go_ff && sts.mul_done) begin
               cmd.mul_l = 1'b0;
               cmd.finish = 1'b1; state_in = glb_pkg::ST_DONE;
            end
         end
         glb_pkg::ST_DONE: begin
            done_o = 1'b1; state_in = glb_pkg::ST_IDLE;
         end
         default: state_in = glb_pkg::ST_IDLE;
      endcase
   end

   `GLB_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy, "start not taken")
   `GLB_ASSERT_NXT(a_done_idle, clock, reset, done_o, !busy, "no return to idle")
   `GLB_ASSERT_IMP(a_one_mul, clock, reset, 1'b1, $onehot0({cmd.mul_s, cmd.mul_t, cmd.mul_l}), "two multiplies")
endmodule

[hw/rtl/gcd_lcm_bezout_unit_top.sv]
// Each Euclid step runs a restoring divide of r0 by r1, then two shift-add
// multiplies (q*s1, q*t1); afterwards, if both operands are nonzero, the lcm
// divide a/g and the multiply (a/g)*b run, then the strobe.
// Throughput: one item at a time; busy stays high through the strobe cycle.
// Synchronous active-high reset returns the controller to idle, no result pending.
//------------------------------------------------------------------------------
// gcd_lcm_bezout_unit_top: extended Euclid unit with lcm
// Returns gcd, Bezout coefficients and saturated lcm for one operand pair.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module gcd_lcm_bezout_unit_top #(
   parameter int DATA_WIDTH = glb_pkg::DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [62:0] req_operand_a,
   input  logic [62:0] req_operand_b,
   output logic        rsp_valid,
   output logic [62:0] rsp_gcd_value,
   output logic signed [63:0] rsp_coef_x,
   output logic signed [63:0] rsp_coef_y,
   output logic [62:0] rsp_lcm_value,
   output logic        rsp_lcm_overflow
);
   glb_pkg::cmd_type cmd;
   glb_pkg::sts_type sts;
   logic [63:0]      x_w, y_w;

   glb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .done_o(rsp_valid), .cmd(cmd), .sts(sts)
   );

   glb_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .gcd_o(rsp_gcd_value), .x_o(x_w), .y_o(y_w),
      .lcm_o(rsp_lcm_value), .ovf_o(rsp_lcm_overflow)
   );

   assign rsp_coef_x = signed'(x_w);
   assign rsp_coef_y = signed'(y_w);
endmodule
